>>> design/delay_profile_window_sum_top_assert.svh
// Assertion macros for the delay profile window sum block.
// Included by the modules that check their own control logic; no dependencies.
`ifndef DELAY_PROFILE_WINDOW_SUM_TOP_ASSERT_SVH
`define DELAY_PROFILE_WINDOW_SUM_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DPWS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dpws check failed");
`define DPWS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dpws check failed");
`else
`define DPWS_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define DPWS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> design/dpws_pkg.sv
// Shared types and constants for the delay profile window sum block.
// No dependencies.
package dpws_pkg;
   localparam int DPWS_MAX_TAPS = 64;
   localparam int MODE_W    = 2;
   localparam int IDX_W     = 6;
   localparam int TAP_W     = 16;
   localparam int CNT_IN_W  = 7;
   localparam int TIME_W    = 32;
   localparam int RES_W     = 31;
   localparam int SUMC_W    = 23;
   localparam int MAG_SUM_W = 22;
   localparam int PEAK_W    = 6;
   localparam int MAG_W     = 16;
   localparam int WORD_W    = 3 * 16;
   localparam int QUO_W     = 34;
   localparam int DSR_W     = 32;
   localparam int RAD_W     = 32;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_BAD_INDEX = 1'b1;

   typedef enum logic [1:0] {
      MODE_WRITE  = 2'd0,
      MODE_RESIZE = 2'd1,
      MODE_PEAK   = 2'd2,
      MODE_WINDOW = 2'd3
   } dpws_mode_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_SQUARE, OP_ROOT_START, OP_WRITE, OP_RSZ_INIT, OP_SWEEP,
      OP_SCAN_INIT, OP_SCAN, OP_DIV_START, OP_BOUND1, OP_BOUND2, OP_SUM, OP_IMP_RD,
      OP_IMP_TAKE, OP_RESULT
   } dpws_op_type;

   typedef struct packed {
      dpws_op_type op;
      logic        div_second;
   } dpws_cmd_type;

   typedef struct packed {
      logic          sweep_done;
      logic          walk_done;
      logic          root_done;
      logic          div_done;
      logic          res_zero;
      logic          negative;
      logic          bad_index;
      dpws_mode_type mode;
   } dpws_stat_type;
endpackage

>>> design/dpws_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on dpws_pkg for the field widths.
interface dpws_req_if import dpws_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic [IDX_W-1:0]         tap_index;
   logic signed [TAP_W-1:0]  tap_real;
   logic signed [TAP_W-1:0]  tap_imag;
   logic [CNT_IN_W-1:0]      new_count;
   logic signed [TIME_W-1:0] offset_time;
   logic signed [TIME_W-1:0] span_time;
   modport source (output valid, mode, tap_index, tap_real, tap_imag, new_count,
                   offset_time, span_time, input ready);
   modport sink (input valid, mode, tap_index, tap_real, tap_imag, new_count,
                 offset_time, span_time, output ready);
endinterface

interface dpws_rsp_if import dpws_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [SUMC_W-1:0] sum_real;
   logic signed [SUMC_W-1:0] sum_imag;
   logic [MAG_SUM_W-1:0]     magnitude_sum;
   logic [PEAK_W-1:0]        peak_index;
   logic                     status;
   modport source (output valid, sum_real, sum_imag, magnitude_sum, peak_index, status,
                   input ready);
   modport sink (input valid, sum_real, sum_imag, magnitude_sum, peak_index, status,
                 output ready);
endinterface

>>> design/dpws_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on dpws_pkg for the operand widths.
module dpws_div import dpws_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [QUO_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             done,
   output logic [QUO_W-1:0] quotient
);
   localparam int CNT_W = $clog2(QUO_W);

   logic             busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DSR_W:0]   rem_ff, rem_in, rem_sh;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic             fits;

   always_comb begin
      rem_sh  = {rem_ff[DSR_W-1:0], quo_ff[QUO_W-1]};
      fits    = rem_sh >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? (rem_sh - {1'b0, dsr_ff}) : rem_sh;
         quo_in = {quo_ff[QUO_W-2:0], fits};
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

>>> design/dpws_isqrt.sv
// Integer square root, one result bit per cycle.
// Depends on dpws_pkg for the radicand and root widths.
module dpws_isqrt import dpws_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [RAD_W-1:0] radicand,
   output logic             done,
   output logic [MAG_W-1:0] root
);
   logic [RAD_W-1:0] val_ff, val_in, root_ff, root_in, bit_ff, bit_in, trial;
   logic             done_ff, done_in;

   always_comb begin
      trial   = root_ff + bit_ff;
      val_in  = val_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      done_in = 1'b0;
      if (start) begin
         val_in  = radicand;
         root_in = '0;
         bit_in  = {2'b01, {(RAD_W-2){1'b0}}};
      end else if (bit_ff != '0) begin
         if (val_ff >= trial) begin
            val_in  = val_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         done_in = (bit_ff >> 2) == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         bit_ff  <= bit_in;
         done_ff <= done_in;
      end
      val_ff  <= val_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff[MAG_W-1:0];
endmodule

>>> design/dpws_dp.sv
// Datapath: tap memory, magnitude and division units, accumulators, result register.
// Depends on dpws_pkg, dpws_div and dpws_isqrt.
module dpws_dp import dpws_pkg::*; #(
   parameter int MAX_TAPS = DPWS_MAX_TAPS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dpws_cmd_type             cmd,
   output dpws_stat_type            stat,
   input  logic                     csr_wr_en,
   input  logic [RES_W-1:0]         csr_wr_data,
   input  logic [MODE_W-1:0]        req_mode,
   input  logic [IDX_W-1:0]         req_tap_index,
   input  logic signed [TAP_W-1:0]  req_tap_real,
   input  logic signed [TAP_W-1:0]  req_tap_imag,
   input  logic [CNT_IN_W-1:0]      req_new_count,
   input  logic signed [TIME_W-1:0] req_offset_time,
   input  logic signed [TIME_W-1:0] req_span_time,
   output logic signed [SUMC_W-1:0] rsp_sum_real,
   output logic signed [SUMC_W-1:0] rsp_sum_imag,
   output logic [MAG_SUM_W-1:0]     rsp_magnitude_sum,
   output logic [PEAK_W-1:0]        rsp_peak_index,
   output logic                     rsp_status
);
   localparam int AW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CW  = $clog2(MAX_TAPS + 1);
   localparam int STW = QUO_W + 1;
   localparam int ENW = QUO_W + 2;

   logic [WORD_W-1:0] mem [MAX_TAPS];
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [WORD_W-1:0] mem_wdata, rdata_ff;

   logic [RES_W-1:0]         res_ff;
   dpws_mode_type            mode_ff, mode_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic signed [TAP_W-1:0]  re_ff, re_in, im_ff, im_in;
   logic [CW-1:0]            ncount_ff, ncount_in, count_ff, count_in;
   logic signed [TIME_W-1:0] off_ff, off_in, span_ff, span_in;
   logic                     bad_ff, bad_in;
   logic [RAD_W-1:0]         sq_re_ff, sq_re_in, sq_im_ff, sq_im_in;
   logic signed [2*TAP_W-1:0] prod_re, prod_im;
   logic [CW-1:0]            addr_ff, addr_in, lo_ff, lo_in, hi_ff, hi_in;
   logic                     pend_ff, pend_in, walk_sum_ff, walk_sum_in;
   logic [AW-1:0]            ridx_ff, ridx_in, peak_ff, peak_in;
   logic [MAG_W-1:0]         best_ff, best_in;
   logic signed [SUMC_W-1:0] acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic [MAG_SUM_W-1:0]     acc_mag_ff, acc_mag_in;
   logic [QUO_W-1:0]         qa_ff, qa_in, qb_ff, qb_in;
   logic                     div_sel_ff, div_sel_in;
   logic [STW-1:0]           st_ff, st_in;
   logic [ENW-1:0]           en_val;
   logic signed [SUMC_W-1:0] out_re_ff, out_re_in, out_im_ff, out_im_in;
   logic [MAG_SUM_W-1:0]     out_mag_ff, out_mag_in;
   logic [PEAK_W-1:0]        out_peak_ff, out_peak_in;
   logic                     out_st_ff, out_st_in;

   logic [CW-1:0]            walk_limit;
   logic                     walk_more, hit, div_rnd, div_done, root_done;
   logic [TIME_W-1:0]        div_x;
   logic [QUO_W-1:0]         div_dividend, div_q;
   logic [DSR_W-1:0]         div_divisor;
   logic [MAG_W-1:0]         root;
   logic signed [TAP_W-1:0]  rd_re, rd_im;
   logic [MAG_W-1:0]         rd_mag;

   assign rd_re  = rdata_ff[TAP_W-1:0];
   assign rd_im  = rdata_ff[2*TAP_W-1:TAP_W];
   assign rd_mag = rdata_ff[WORD_W-1:2*TAP_W];
   assign prod_re = re_ff * re_ff;
   assign prod_im = im_ff * im_ff;

   assign walk_limit = walk_sum_ff ? hi_ff : count_ff;
   assign walk_more  = addr_ff < walk_limit;

   assign div_rnd      = !cmd.div_second || (mode_ff == MODE_WINDOW);
   assign div_x        = cmd.div_second ? off_ff : span_ff;
   assign div_dividend = div_rnd ? (QUO_W'({div_x, 1'b0}) + QUO_W'(res_ff)) : QUO_W'(div_x);
   assign div_divisor  = div_rnd ? {res_ff, 1'b0} : DSR_W'(res_ff);

   assign hit = (mode_ff == MODE_PEAK) ? (off_ff == '0)
                                       : (off_ff[TIME_W-1] && !span_ff[TIME_W-1] &&
                                          (span_ff != '0));

   dpws_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_DIV_START),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   dpws_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_ROOT_START),
      .radicand (sq_re_ff + sq_im_ff),
      .done     (root_done),
      .root     (root)
   );

   always_comb begin
      mode_in     = mode_ff;
      idx_in      = idx_ff;
      re_in       = re_ff;
      im_in       = im_ff;
      ncount_in   = ncount_ff;
      count_in    = count_ff;
      off_in      = off_ff;
      span_in     = span_ff;
      bad_in      = bad_ff;
      sq_re_in    = sq_re_ff;
      sq_im_in    = sq_im_ff;
      addr_in     = addr_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      pend_in     = pend_ff;
      walk_sum_in = walk_sum_ff;
      ridx_in     = ridx_ff;
      peak_in     = peak_ff;
      best_in     = best_ff;
      acc_re_in   = acc_re_ff;
      acc_im_in   = acc_im_ff;
      acc_mag_in  = acc_mag_ff;
      qa_in       = qa_ff;
      qb_in       = qb_ff;
      div_sel_in  = div_sel_ff;
      st_in       = st_ff;
      en_val      = '0;
      out_re_in   = out_re_ff;
      out_im_in   = out_im_ff;
      out_mag_in  = out_mag_ff;
      out_peak_in = out_peak_ff;
      out_st_in   = out_st_ff;
      mem_we      = 1'b0;
      mem_waddr   = addr_ff[AW-1:0];
      mem_wdata   = '0;
      mem_re      = 1'b0;
      mem_raddr   = addr_ff[AW-1:0];

      if (div_done) begin
         if (div_sel_ff) begin
            qb_in = div_q;
         end else begin
            qa_in = div_q;
         end
      end

      case (cmd.op)
         OP_LOAD: begin
            mode_in    = dpws_mode_type'(req_mode);
            idx_in     = req_tap_index;
            re_in      = req_tap_real;
            im_in      = req_tap_imag;
            off_in     = req_offset_time;
            span_in    = req_span_time;
            ncount_in  = (32'(req_new_count) > 32'(MAX_TAPS)) ? CW'(MAX_TAPS)
                                                              : CW'(req_new_count);
            bad_in     = (dpws_mode_type'(req_mode) == MODE_WRITE) &&
                         (32'(req_tap_index) >= 32'(MAX_TAPS));
            acc_re_in  = '0;
            acc_im_in  = '0;
            acc_mag_in = '0;
            peak_in    = '0;
            best_in    = '0;
         end
         OP_SQUARE: begin
            sq_re_in = RAD_W'(unsigned'(prod_re));
            sq_im_in = RAD_W'(unsigned'(prod_im));
         end
         OP_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(32'(idx_ff));
            mem_wdata = {root, im_ff, re_ff};
            if (32'(idx_ff) >= 32'(count_ff)) begin
               count_in = CW'(32'(idx_ff) + 32'd1);
            end
         end
         OP_RSZ_INIT: begin
            addr_in  = ncount_ff;
            count_in = ncount_ff;
         end
         OP_SWEEP: begin
            mem_we  = 1'b1;
            addr_in = addr_ff + 1'b1;
         end
         OP_SCAN_INIT: begin
            addr_in     = '0;
            pend_in     = 1'b0;
            walk_sum_in = 1'b0;
         end
         OP_SCAN, OP_SUM: begin
            mem_re  = walk_more;
            pend_in = walk_more;
            ridx_in = addr_ff[AW-1:0];
            if (walk_more) begin
               addr_in = addr_ff + 1'b1;
            end
            if (pend_ff) begin
               if (cmd.op == OP_SCAN) begin
                  if (rd_mag > best_ff) begin
                     best_in = rd_mag;
                     peak_in = ridx_ff;
                  end
               end else begin
                  acc_re_in  = acc_re_ff + SUMC_W'(rd_re);
                  acc_im_in  = acc_im_ff + SUMC_W'(rd_im);
                  acc_mag_in = acc_mag_ff + MAG_SUM_W'(rd_mag);
               end
            end
         end
         OP_DIV_START: begin
            div_sel_in = cmd.div_second;
         end
         OP_BOUND1: begin
            st_in = STW'(qb_ff) + ((mode_ff == MODE_PEAK) ? STW'(peak_ff) : '0);
         end
         OP_BOUND2: begin
            en_val = (mode_ff == MODE_PEAK) ? (ENW'(st_ff) + ENW'(qa_ff)) : ENW'(qa_ff);
            if (st_ff >= STW'(count_ff)) begin
               lo_in = count_ff;
               hi_in = count_ff;
            end else begin
               lo_in = st_ff[CW-1:0];
               hi_in = (en_val >= ENW'(count_ff)) ? count_ff : en_val[CW-1:0];
            end
            addr_in     = lo_in;
            pend_in     = 1'b0;
            walk_sum_in = 1'b1;
         end
         OP_IMP_RD: begin
            mem_re    = 1'b1;
            mem_raddr = '0;
         end
         OP_IMP_TAKE: begin
            if (hit) begin
               acc_re_in  = SUMC_W'(rd_re);
               acc_im_in  = SUMC_W'(rd_im);
               acc_mag_in = MAG_SUM_W'(rd_mag);
            end
         end
         OP_RESULT: begin
            out_re_in   = acc_re_ff;
            out_im_in   = acc_im_ff;
            out_mag_in  = acc_mag_ff;
            out_peak_in = PEAK_W'(peak_ff);
            out_st_in   = bad_ff ? STATUS_BAD_INDEX : STATUS_OK;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff      <= RES_W'(1);
         count_ff    <= '0;
         addr_ff     <= '0;
         pend_ff     <= 1'b0;
         walk_sum_ff <= 1'b0;
         div_sel_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            res_ff <= csr_wr_data;
         end
         count_ff    <= count_in;
         addr_ff     <= addr_in;
         pend_ff     <= pend_in;
         walk_sum_ff <= walk_sum_in;
         div_sel_ff  <= div_sel_in;
      end
      mode_ff     <= mode_in;
      idx_ff      <= idx_in;
      re_ff       <= re_in;
      im_ff       <= im_in;
      ncount_ff   <= ncount_in;
      off_ff      <= off_in;
      span_ff     <= span_in;
      bad_ff      <= bad_in;
      sq_re_ff    <= sq_re_in;
      sq_im_ff    <= sq_im_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      ridx_ff     <= ridx_in;
      peak_ff     <= peak_in;
      best_ff     <= best_in;
      acc_re_ff   <= acc_re_in;
      acc_im_ff   <= acc_im_in;
      acc_mag_ff  <= acc_mag_in;
      qa_ff       <= qa_in;
      qb_ff       <= qb_in;
      st_ff       <= st_in;
      out_re_ff   <= out_re_in;
      out_im_ff   <= out_im_in;
      out_mag_ff  <= out_mag_in;
      out_peak_ff <= out_peak_in;
      out_st_ff   <= out_st_in;
   end

   always_comb begin
      stat.sweep_done = addr_ff == CW'(MAX_TAPS);
      stat.walk_done  = !pend_ff && !walk_more;
      stat.root_done  = root_done;
      stat.div_done   = div_done;
      stat.res_zero   = res_ff == '0;
      stat.negative   = off_ff[TIME_W-1] || span_ff[TIME_W-1];
      stat.bad_index  = bad_ff;
      stat.mode       = mode_ff;
   end

   assign rsp_sum_real      = out_re_ff;
   assign rsp_sum_imag      = out_im_ff;
   assign rsp_magnitude_sum = out_mag_ff;
   assign rsp_peak_index    = out_peak_ff;
   assign rsp_status        = out_st_ff;
endmodule

>>> design/dpws_ctrl.sv
// Controller state machine: sequences the datapath and owns the handshakes.
// Depends on dpws_pkg and the assertion macro header.
`include "delay_profile_window_sum_top_assert.svh"
module dpws_ctrl import dpws_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dpws_cmd_type  cmd,
   input  dpws_stat_type stat
);
   typedef enum logic [13:0] {
      S_CLEAR    = 14'b00000000000001,
      S_IDLE     = 14'b00000000000010,
      S_DISPATCH = 14'b00000000000100,
      S_ROOT_GO  = 14'b00000000001000,
      S_ROOT     = 14'b00000000010000,
      S_RESIZE   = 14'b00000000100000,
      S_SCAN     = 14'b00000001000000,
      S_DIV_A    = 14'b00000010000000,
      S_DIV_B    = 14'b00000100000000,
      S_BOUND1   = 14'b00001000000000,
      S_BOUND2   = 14'b00010000000000,
      S_SUM      = 14'b00100000000000,
      S_IMP_TAKE = 14'b01000000000000,
      S_DONE     = 14'b10000000000000
   } dpws_state_type;

   dpws_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in       = state_ff;
      cmd.op         = OP_NONE;
      cmd.div_second = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_CLEAR: begin
            if (stat.sweep_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.op = OP_SWEEP;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.mode)
               MODE_WRITE: begin
                  if (stat.bad_index) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.op   = OP_SQUARE;
                     state_in = S_ROOT_GO;
                  end
               end
               MODE_RESIZE: begin
                  cmd.op   = OP_RSZ_INIT;
                  state_in = S_RESIZE;
               end
               default: begin
                  if (stat.res_zero) begin
                     cmd.op   = OP_IMP_RD;
                     state_in = S_IMP_TAKE;
                  end else if (stat.mode == MODE_PEAK) begin
                     cmd.op   = OP_SCAN_INIT;
                     state_in = S_SCAN;
                  end else if (stat.negative) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.op   = OP_DIV_START;
                     state_in = S_DIV_A;
                  end
               end
            endcase
         end
         S_ROOT_GO: begin
            cmd.op   = OP_ROOT_START;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (stat.root_done) begin
               cmd.op   = OP_WRITE;
               state_in = S_DONE;
            end
         end
         S_RESIZE: begin
            if (stat.sweep_done) begin
               state_in = S_DONE;
            end else begin
               cmd.op = OP_SWEEP;
            end
         end
         S_SCAN: begin
            cmd.op = OP_SCAN;
            if (stat.walk_done) begin
               if (stat.negative) begin
                  cmd.op   = OP_NONE;
                  state_in = S_DONE;
               end else begin
                  cmd.op   = OP_DIV_START;
                  state_in = S_DIV_A;
               end
            end
         end
         S_DIV_A: begin
            if (stat.div_done) begin
               cmd.op         = OP_DIV_START;
               cmd.div_second = 1'b1;
               state_in       = S_DIV_B;
            end
         end
         S_DIV_B: begin
            if (stat.div_done) begin
               state_in = S_BOUND1;
            end
         end
         S_BOUND1: begin
            cmd.op   = OP_BOUND1;
            state_in = S_BOUND2;
         end
         S_BOUND2: begin
            cmd.op   = OP_BOUND2;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.op = OP_SUM;
            if (stat.walk_done) begin
               state_in = S_DONE;
            end
         end
         S_IMP_TAKE: begin
            cmd.op   = OP_IMP_TAKE;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   `DPWS_ASSERT_NEXT(a_accept_dispatch, clock, reset, (state_ff == S_IDLE) && req_valid, state_ff == S_DISPATCH)
   `DPWS_ASSERT_NEXT(a_result_waits, clock, reset, (state_ff == S_DONE) && rsp_valid_ff && !rsp_ready, (state_ff == S_DONE) && rsp_valid_ff)
   `DPWS_ASSERT_SAME(a_result_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_DONE))
   `DPWS_ASSERT_NEXT(a_write_finishes, clock, reset, (state_ff == S_ROOT) && stat.root_done, state_ff == S_DONE)
endmodule

>>> design/delay_profile_window_sum_top.sv
// Top level of the delay profile window sum block.
// Depends on dpws_pkg, dpws_if, dpws_ctrl and dpws_dp.
//
//   Channel   Direction   Handshake          Carries
//   req_ch    in          valid/ready        mode, tap, count and time fields
//   rsp_ch    out         valid/ready        sums, peak index, status
//   csr_*     in          write enable only  resolution_ticks
//
// After reset a clearing pass zeroes the tap memory; no request is taken until it
// ends. A tap write waits for the bit-serial square root. A resize zeroes the taps
// from the new count to the end of the memory in a sweep. A sum from the peak walks
// the taps for the peak, runs two serial divisions and then walks the window; a
// window sum drops the peak walk.
// A result held in the output register does not stop the next request being taken.
module delay_profile_window_sum_top import dpws_pkg::*; #(
   parameter int MAX_TAPS = DPWS_MAX_TAPS
) (
   input  logic             clock,
   input  logic             reset,
   dpws_req_if.sink         req_ch,
   dpws_rsp_if.source       rsp_ch,
   input  logic             csr_wr_en,
   input  logic [RES_W-1:0] csr_wr_data
);
   dpws_cmd_type  cmd;
   dpws_stat_type stat;

   dpws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   dpws_dp #(.MAX_TAPS(MAX_TAPS)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_mode          (req_ch.mode),
      .req_tap_index     (req_ch.tap_index),
      .req_tap_real      (req_ch.tap_real),
      .req_tap_imag      (req_ch.tap_imag),
      .req_new_count     (req_ch.new_count),
      .req_offset_time   (req_ch.offset_time),
      .req_span_time     (req_ch.span_time),
      .rsp_sum_real      (rsp_ch.sum_real),
      .rsp_sum_imag      (rsp_ch.sum_imag),
      .rsp_magnitude_sum (rsp_ch.magnitude_sum),
      .rsp_peak_index    (rsp_ch.peak_index),
      .rsp_status        (rsp_ch.status)
   );
endmodule

>>> tb/tb_dpws_channels.sv
// Testbench view of the request and response channels of the delay profile block.
// Holds the expected result struct; the channel interfaces come from the design's dpws_if.
// Depends on dpws_pkg.
package tb_dpws_channels_pkg;
   import dpws_pkg::*;

   typedef struct packed {
      logic signed [SUMC_W-1:0] sum_real;
      logic signed [SUMC_W-1:0] sum_imag;
      logic [MAG_SUM_W-1:0]     magnitude_sum;
      logic [PEAK_W-1:0]        peak_index;
      logic                     status;
   } tap_result_type;
endpackage

>>> tb/tb_top.sv
// Self-checking testbench for delay_profile_window_sum_top.
// Drives taps, resizes and both kinds of sum, predicts each response and compares it.
// Depends on dpws_pkg, dpws_if, tb_dpws_channels_pkg and the block's RTL.
module tb_top;
   import dpws_pkg::*;
   import tb_dpws_channels_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [RES_W-1:0] csr_wr_data = '0;

   dpws_req_if req_ch ();
   dpws_rsp_if rsp_ch ();

   delay_profile_window_sum_top i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #6 clock = ~clock;

   logic [31:0] model_taps [DPWS_MAX_TAPS];
   int unsigned model_count;
   longint unsigned model_res;
   tap_result_type expected_sums [$];
   int error_count = 0;
   bit quiet_tail = 1'b0;
   bit sink_hold = 1'b0;
   int src_gap_pct = 20;

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 32;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint signed tap_re(input int i);
      return longint'($signed(model_taps[i][15:0]));
   endfunction

   function automatic longint signed tap_im(input int i);
      return longint'($signed(model_taps[i][31:16]));
   endfunction

   function automatic longint unsigned tap_mag(input int i);
      longint signed r, m;
      r = tap_re(i);
      m = tap_im(i);
      return int_sqrt(longint'(r * r + m * m));
   endfunction

   function automatic longint unsigned div_round(input longint unsigned x,
                                                 input longint unsigned d);
      return (2 * x + d) / (2 * d);
   endfunction

   function automatic tap_result_type predict_response(
      input dpws_mode_type mode, input logic [5:0] idx, input logic [15:0] re,
      input logic [15:0] im, input logic [6:0] cnt, input logic signed [31:0] off,
      input logic signed [31:0] span);
      tap_result_type r;
      longint signed sr, si, best, m;
      longint unsigned sm, st, en, n;
      int unsigned peak, k;
      bit hit;
      sr = 0; si = 0; sm = 0; peak = 0; best = -1;
      r.status = STATUS_OK;
      case (mode)
         MODE_WRITE: begin
            model_taps[idx] = {im, re};
            if (idx >= model_count) model_count = idx + 1;
         end
         MODE_RESIZE: begin
            n = (cnt > DPWS_MAX_TAPS) ? DPWS_MAX_TAPS : cnt;
            for (k = 32'(n); k < DPWS_MAX_TAPS; k++) model_taps[k] = '0;
            model_count = 32'(n);
         end
         default: begin
            if (model_res == 0) begin
               hit = (mode == MODE_PEAK) ? (off == 0) : (off < 0 && span > 0);
               if (hit) begin
                  sr = tap_re(0); si = tap_im(0); sm = tap_mag(0);
               end
            end else begin
               st = 1; en = 0;
               if (mode == MODE_PEAK) begin
                  for (k = 0; k < model_count; k++) begin
                     m = tap_mag(k);
                     if (m > best) begin
                        best = m; peak = k;
                     end
                  end
                  if (off >= 0 && span >= 0) begin
                     st = peak + longint'(off) / model_res;
                     en = st + div_round(span, model_res);
                  end
               end else if (off >= 0 && span >= 0) begin
                  st = div_round(off, model_res);
                  en = div_round(span, model_res);
               end
               if (en > model_count) en = model_count;
               for (longint unsigned j = st; j < en; j++) begin
                  sr += tap_re(int'(j)); si += tap_im(int'(j)); sm += tap_mag(int'(j));
               end
            end
         end
      endcase
      r.sum_real = sr[SUMC_W-1:0];
      r.sum_imag = si[SUMC_W-1:0];
      r.magnitude_sum = sm[MAG_SUM_W-1:0];
      r.peak_index = peak[5:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint exp);
      $display("error: %s got %0d expected %0d at %0t", what, got, exp, $realtime);
      error_count++;
   endtask

   task automatic send_item(input dpws_mode_type mode, input logic [5:0] idx,
                            input logic [15:0] re, input logic [15:0] im,
                            input logic [6:0] cnt, input logic signed [31:0] off,
                            input logic signed [31:0] span);
      if (!quiet_tail && $urandom_range(99) < src_gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(14, 1)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= mode;
      req_ch.tap_index <= idx;
      req_ch.tap_real <= re;
      req_ch.tap_imag <= im;
      req_ch.new_count <= cnt;
      req_ch.offset_time <= off;
      req_ch.span_time <= span;
      do @(posedge clock); while (!req_ch.ready);
      expected_sums.push_back(predict_response(mode, idx, re, im, cnt, off, span));
      @(negedge clock);
   endtask

   task automatic drain_and_wait();
      req_ch.valid <= 1'b0;
      while (expected_sums.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic write_resolution(input longint unsigned value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[RES_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      model_res = value & 64'h7FFF_FFFF;
   endtask

   task automatic random_item();
      int unsigned sel;
      logic signed [31:0] off, span;
      sel = $urandom_range(99);
      if ($urandom_range(9) == 0) begin
         off = $urandom(); span = $urandom();
      end else begin
         off = 32'($urandom_range(70) * (model_res == 0 ? 1 : model_res)
                   + $urandom_range(3));
         span = 32'($urandom_range(70) * (model_res == 0 ? 1 : model_res)
                    + $urandom_range(3));
         if ($urandom_range(15) == 0) off = -off;
         if ($urandom_range(15) == 0) span = -span;
      end
      if (sel < 45)
         send_item(MODE_WRITE, 6'($urandom()), 16'($urandom()), 16'($urandom()),
                   7'($urandom()), off, span);
      else if (sel < 52)
         send_item(MODE_RESIZE, 6'($urandom()), 16'($urandom()), 16'($urandom()),
                   7'($urandom_range(3) == 0 ? $urandom() : $urandom_range(64)), off, span);
      else if (sel < 76)
         send_item(MODE_PEAK, 6'($urandom()), 16'($urandom()), 16'($urandom()),
                   7'($urandom()), off, span);
      else
         send_item(MODE_WINDOW, 6'($urandom()), 16'($urandom()), 16'($urandom()),
                   7'($urandom()), off, span);
   endtask

   task automatic test_directed();
      send_item(MODE_PEAK, 0, 0, 0, 0, 0, 5);
      send_item(MODE_WRITE, 0, 16'h7FFF, 16'h8000, 0, 0, 0);
      send_item(MODE_WRITE, 63, 16'h8000, 16'h8000, 0, 0, 0);
      send_item(MODE_WRITE, 5, 16'hFFFF, 16'h0001, 0, 0, 0);
      send_item(MODE_PEAK, 0, 0, 0, 0, 0, 64);
      send_item(MODE_PEAK, 0, 0, 0, 0, -1, 3);
      send_item(MODE_PEAK, 0, 0, 0, 0, 2, -3);
      send_item(MODE_WINDOW, 0, 0, 0, 0, 0, 64);
      send_item(MODE_WINDOW, 0, 0, 0, 0, 10, 3);
      send_item(MODE_WINDOW, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_item(MODE_WINDOW, 0, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF);
      send_item(MODE_RESIZE, 0, 0, 0, 7'h7F, 0, 0);
      send_item(MODE_RESIZE, 0, 0, 0, 3, 0, 0);
      send_item(MODE_PEAK, 0, 0, 0, 0, 0, 64);
      send_item(MODE_RESIZE, 0, 0, 0, 0, 0, 0);
      send_item(MODE_WINDOW, 0, 0, 0, 0, 0, 64);
      drain_and_wait();
      write_resolution(0);
      send_item(MODE_WRITE, 0, 16'h1234, 16'hF000, 0, 0, 0);
      send_item(MODE_PEAK, 0, 0, 0, 0, 0, 9);
      send_item(MODE_PEAK, 0, 0, 0, 0, 1, 9);
      send_item(MODE_WINDOW, 0, 0, 0, 0, -1, 1);
      send_item(MODE_WINDOW, 0, 0, 0, 0, -1, 0);
      send_item(MODE_WINDOW, 0, 0, 0, 0, 0, 1);
      drain_and_wait();
   endtask

   task automatic test_random_phase(input longint unsigned res, input int items);
      write_resolution(res);
      repeat (items) random_item();
      drain_and_wait();
   endtask

   task automatic test_backpressure();
      sink_hold = 1'b1;
      src_gap_pct = 0;
      repeat (12) random_item();
      src_gap_pct = 20;
      drain_and_wait();
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_WRITE;
      req_ch.tap_index = '0;
      req_ch.tap_real = '0;
      req_ch.tap_imag = '0;
      req_ch.new_count = '0;
      req_ch.offset_time = '0;
      req_ch.span_time = '0;
      for (int k = 0; k < DPWS_MAX_TAPS; k++) model_taps[k] = '0;
      model_count = 0;
      model_res = 1;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_phase(1, 300);
      test_backpressure();
      test_random_phase(3, 250);
      test_random_phase(64'h7FFF_FFFF, 60);
      test_random_phase(0, 100);
      test_random_phase(10, 250);
      quiet_tail = 1'b1;
      test_random_phase(1, 200);
      if (error_count == 0) begin
         $display("delay_profile_window_sum_top: match");
      end else begin
         $display("delay_profile_window_sum_top: mismatch");
      end
      $finish;
   end

   initial begin
      int hold_cycles;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_hold) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles = 0;
            while (hold_cycles < 2500) begin
               @(negedge clock);
               hold_cycles++;
            end
            sink_hold = 1'b0;
         end else if (!quiet_tail && $urandom_range(99) < 15) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(14, 1)) @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      tap_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_sums.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            want = expected_sums.pop_front();
            if (rsp_ch.sum_real !== want.sum_real)
               report_mismatch("sum_real", rsp_ch.sum_real, want.sum_real);
            if (rsp_ch.sum_imag !== want.sum_imag)
               report_mismatch("sum_imag", rsp_ch.sum_imag, want.sum_imag);
            if (rsp_ch.magnitude_sum !== want.magnitude_sum)
               report_mismatch("magnitude_sum", rsp_ch.magnitude_sum, want.magnitude_sum);
            if (rsp_ch.peak_index !== want.peak_index)
               report_mismatch("peak_index", rsp_ch.peak_index, want.peak_index);
            if (rsp_ch.status !== want.status)
               report_mismatch("status", rsp_ch.status, want.status);
         end
      end
   end

   initial begin
      #20ms;
      $display("delay_profile_window_sum_top: mismatch");
      $finish;
   end
endmodule
